// File: sv/redundant_card_role_fsm_top_macros.svh
// ----------------------------------------------------------------------------
// redundant_card_role_fsm_top_macros.svh
// assertion macros shared by the role controller
// ----------------------------------------------------------------------------
`ifndef REDUNDANT_CARD_ROLE_FSM_TOP_MACROS_SVH
`define REDUNDANT_CARD_ROLE_FSM_TOP_MACROS_SVH

// checked only while out of reset
`define RCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RCR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rcr_fsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_fsm_pkg
// codes and constants of the redundant card role controller
// ----------------------------------------------------------------------------
package rcr_fsm_pkg;

	typedef logic [2:0] role_t;
	typedef logic [1:0] func_t;
	typedef logic [1:0] hw_role_t;
	typedef logic [1:0] event_t;

	localparam role_t ST_WARMUP    = 3'd0;
	localparam role_t ST_COLD_ACT  = 3'd1;
	localparam role_t ST_COLD_STBY = 3'd2;
	localparam role_t ST_HOT_ACT   = 3'd3;
	localparam role_t ST_HOT_STBY  = 3'd4;
	localparam role_t ST_FAIL      = 3'd5;
	localparam role_t ST_OFFLINE   = 3'd6;
	localparam role_t ST_UNKNOWN   = 3'd7;

	localparam func_t FN_TICK    = 2'd0;
	localparam func_t FN_TWIN    = 2'd1;
	localparam func_t FN_FAIL    = 2'd2;
	localparam func_t FN_OFFLINE = 2'd3;

	localparam hw_role_t HW_STANDBY = 2'd0;
	localparam hw_role_t HW_ACTIVE  = 2'd1;

	localparam event_t EV_NONE  = 2'd0;
	localparam event_t EV_RAISE = 2'd1;
	localparam event_t EV_CLEAR = 2'd2;

	localparam int AGE_W = 15;
	localparam int TICKS_W = 32;

	localparam logic [AGE_W-1:0]   AGE_LIMIT    = 15'd20000;
	localparam logic [AGE_W-1:0]   AGE_REWIND   = 15'd10000;
	localparam logic [TICKS_W-1:0] SETTLE_TICKS = 32'd3;

endpackage

// File: sv/redundant_card_role_fsm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_card_role_fsm_top
// active/standby role controller for one card of a redundant pair
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall): one transaction is a tick, a twin
//   status report, a fail command or an offline command (func selects).
//   result channel (result_valid / result_stall): one transaction per item with
//   the new role, the change flag, the raise/clear events, the rtc sync
//   request and the twin and counter values after the item.
//   latency: the result appears the cycle after the item is taken.
//   throughput: one item per cycle while item_stall is low; the role state,
//   counters and result register all update in the accepting cycle from one
//   pass of next-state logic.
//   stall: a stalled result holds in the output register; item_stall rises
//   only while that register is full and stalled, and a new item is taken in
//   the same cycle the waiting result leaves.
//   reset: role warmup, time in state 0, twin warmup, twin freshness 10000,
//   cross sync good, result register empty.
// ----------------------------------------------------------------------------
`include "redundant_card_role_fsm_top_macros.svh"

module redundant_card_role_fsm_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [1:0]  fpga_active,
	input  logic        is_warm,
	input  logic        xsync_ok,
	input  logic [2:0]  twin_code,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  card_state,
	output logic        state_changed,
	output logic        tick_status,
	output logic [1:0]  active_event,
	output logic [1:0]  standby_event,
	output logic [1:0]  xsync_event,
	output logic        rtc_sync_request,
	output logic [2:0]  twin_state,
	output logic [14:0] twin_freshness,
	output logic [31:0] state_ticks
);

	localparam int AW = rcr_fsm_pkg::AGE_W;
	localparam int TW = rcr_fsm_pkg::TICKS_W;

	// architectural state
	rcr_fsm_pkg::role_t role_q;
	logic [TW-1:0]      ticks_q;
	rcr_fsm_pkg::role_t twin_q;
	logic [AW-1:0]      age_q;
	logic               sync_good_q;

	// result register
	logic                  res_valid_q;
	rcr_fsm_pkg::role_t    res_role_q;
	logic                  res_changed_q;
	logic                  res_tstat_q;
	rcr_fsm_pkg::event_t   res_act_ev_q;
	rcr_fsm_pkg::event_t   res_stby_ev_q;
	rcr_fsm_pkg::event_t   res_xs_ev_q;
	logic                  res_rtc_q;
	rcr_fsm_pkg::role_t    res_twin_q;
	logic [AW-1:0]         res_age_q;
	logic [TW-1:0]         res_ticks_q;

	// next-state values
	rcr_fsm_pkg::role_t  role_d;
	logic [TW-1:0]       ticks_d;
	rcr_fsm_pkg::role_t  twin_d;
	logic [AW-1:0]       age_d;
	logic                sync_good_d;
	logic                changed;
	logic                tstat;
	logic                rtc;
	rcr_fsm_pkg::event_t act_ev;
	rcr_fsm_pkg::event_t stby_ev;
	rcr_fsm_pkg::event_t xs_ev;

	logic                do_enter;
	rcr_fsm_pkg::role_t  target;
	logic [AW-1:0]       age_inc;
	logic [TW-1:0]       ticks_inc;
	logic                act_hw;
	logic                stby_hw;
	logic                accept;

	assign accept     = item_valid && !item_stall;
	assign item_stall = res_valid_q && result_stall;

	assign act_hw  = (fpga_active == rcr_fsm_pkg::HW_ACTIVE);
	assign stby_hw = (fpga_active == rcr_fsm_pkg::HW_STANDBY);

	assign age_inc   = age_q + AW'(1);
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + TW'(1);

	// pick the role transition requested by this item, with the rtc request and cross-sync event
	always_comb begin
		do_enter    = 1'b0;
		target      = role_q;
		rtc         = 1'b0;
		xs_ev       = rcr_fsm_pkg::EV_NONE;
		sync_good_d = sync_good_q;
		case (func)
			rcr_fsm_pkg::FN_TICK: begin
				case (role_q)
					rcr_fsm_pkg::ST_WARMUP: begin
						if (act_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_COLD_ACT;
						end else if (stby_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_COLD_STBY;
						end
					end
					rcr_fsm_pkg::ST_COLD_ACT, rcr_fsm_pkg::ST_COLD_STBY: begin
						if (is_warm && act_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_HOT_ACT;
						end else if (is_warm && stby_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_HOT_STBY;
						end else if (role_q == rcr_fsm_pkg::ST_COLD_ACT && stby_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_COLD_STBY;
						end else if (role_q == rcr_fsm_pkg::ST_COLD_STBY && act_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_COLD_ACT;
						end
					end
					rcr_fsm_pkg::ST_HOT_ACT: begin
						if (act_hw) begin
							rtc = (ticks_inc == rcr_fsm_pkg::SETTLE_TICKS);
						end else if (stby_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_HOT_STBY;
						end
					end
					rcr_fsm_pkg::ST_HOT_STBY: begin
						if (act_hw) begin
							do_enter = 1'b1;
							target   = rcr_fsm_pkg::ST_HOT_ACT;
						end else if (ticks_inc > rcr_fsm_pkg::SETTLE_TICKS) begin
							// cross sync is only watched once hot standby has settled
							if (sync_good_q && !xsync_ok) begin
								sync_good_d = 1'b0;
								xs_ev       = rcr_fsm_pkg::EV_RAISE;
							end else if (!sync_good_q && xsync_ok) begin
								sync_good_d = 1'b1;
								xs_ev       = rcr_fsm_pkg::EV_CLEAR;
							end
						end
					end
					default: begin
					end
				endcase
			end
			rcr_fsm_pkg::FN_FAIL: begin
				do_enter = 1'b1;
				target   = rcr_fsm_pkg::ST_FAIL;
			end
			rcr_fsm_pkg::FN_OFFLINE: begin
				do_enter = 1'b1;
				target   = rcr_fsm_pkg::ST_OFFLINE;
			end
			default: begin
			end
		endcase

		changed = do_enter && (target != role_q);
		if (changed && role_q == rcr_fsm_pkg::ST_HOT_STBY && !sync_good_q) begin
			sync_good_d = 1'b1;
			xs_ev       = rcr_fsm_pkg::EV_CLEAR;
		end
	end

	// events, counters and twin record
	always_comb begin
		role_d  = role_q;
		act_ev  = rcr_fsm_pkg::EV_NONE;
		stby_ev = rcr_fsm_pkg::EV_NONE;
		twin_d  = twin_q;
		age_d   = age_q;
		ticks_d = ticks_q;

		if (func == rcr_fsm_pkg::FN_TICK) begin
			age_d   = (age_inc >= rcr_fsm_pkg::AGE_LIMIT) ? rcr_fsm_pkg::AGE_REWIND : age_inc;
			ticks_d = ticks_inc;
		end else if (func == rcr_fsm_pkg::FN_TWIN) begin
			if (twin_q != twin_code) begin
				twin_d  = twin_code;
				ticks_d = '0;
			end
			age_d = '0;
		end

		if (changed) begin
			role_d  = target;
			ticks_d = '0;
			// moves between cold and hot of the same side keep the event quiet
			if ((role_q == rcr_fsm_pkg::ST_COLD_ACT && target != rcr_fsm_pkg::ST_HOT_ACT) ||
			    (role_q == rcr_fsm_pkg::ST_HOT_ACT && target != rcr_fsm_pkg::ST_COLD_ACT)) begin
				act_ev = rcr_fsm_pkg::EV_CLEAR;
			end
			if ((role_q == rcr_fsm_pkg::ST_COLD_STBY && target != rcr_fsm_pkg::ST_HOT_STBY) ||
			    (role_q == rcr_fsm_pkg::ST_HOT_STBY && target != rcr_fsm_pkg::ST_COLD_STBY)) begin
				stby_ev = rcr_fsm_pkg::EV_CLEAR;
			end
			if ((target == rcr_fsm_pkg::ST_COLD_ACT && role_q != rcr_fsm_pkg::ST_HOT_ACT) ||
			    (target == rcr_fsm_pkg::ST_HOT_ACT && role_q != rcr_fsm_pkg::ST_COLD_ACT)) begin
				act_ev = rcr_fsm_pkg::EV_RAISE;
			end
			if ((target == rcr_fsm_pkg::ST_COLD_STBY && role_q != rcr_fsm_pkg::ST_HOT_STBY) ||
			    (target == rcr_fsm_pkg::ST_HOT_STBY && role_q != rcr_fsm_pkg::ST_COLD_STBY)) begin
				stby_ev = rcr_fsm_pkg::EV_RAISE;
			end
			// both cards cannot be active: forget a twin that claims to be
			if ((target == rcr_fsm_pkg::ST_COLD_ACT || target == rcr_fsm_pkg::ST_HOT_ACT) &&
			    (twin_q == rcr_fsm_pkg::ST_COLD_ACT || twin_q == rcr_fsm_pkg::ST_HOT_ACT)) begin
				twin_d = rcr_fsm_pkg::ST_UNKNOWN;
			end
		end

		tstat = (func == rcr_fsm_pkg::FN_TICK) &&
		        (changed || role_q == rcr_fsm_pkg::ST_FAIL || role_q == rcr_fsm_pkg::ST_OFFLINE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q      <= rcr_fsm_pkg::ST_WARMUP;
			ticks_q     <= '0;
			twin_q      <= rcr_fsm_pkg::ST_WARMUP;
			age_q       <= rcr_fsm_pkg::AGE_REWIND;
			sync_good_q <= 1'b1;
		end else if (accept) begin
			role_q      <= role_d;
			ticks_q     <= ticks_d;
			twin_q      <= twin_d;
			age_q       <= age_d;
			sync_good_q <= sync_good_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_role_q    <= role_d;
			res_changed_q <= changed;
			res_tstat_q   <= tstat;
			res_act_ev_q  <= act_ev;
			res_stby_ev_q <= stby_ev;
			res_xs_ev_q   <= xs_ev;
			res_rtc_q     <= rtc;
			res_twin_q    <= twin_d;
			res_age_q     <= age_d;
			res_ticks_q   <= ticks_d;
		end
	end

	assign result_valid     = res_valid_q;
	assign card_state       = res_role_q;
	assign state_changed    = res_changed_q;
	assign tick_status      = res_tstat_q;
	assign active_event     = res_act_ev_q;
	assign standby_event    = res_stby_ev_q;
	assign xsync_event      = res_xs_ev_q;
	assign rtc_sync_request = res_rtc_q;
	assign twin_state       = res_twin_q;
	assign twin_freshness   = res_age_q;
	assign state_ticks      = res_ticks_q;

	`RCR_ASSERT(a_accept_gives_result, accept |=> result_valid, "accepted item left no result")
	`RCR_ASSERT(a_change_restarts_ticks, (result_valid && state_changed) |-> (state_ticks == '0), "role change without time-in-state restart")
	`RCR_ASSERT(a_active_raise_role, (result_valid && active_event == rcr_fsm_pkg::EV_RAISE) |-> (card_state == rcr_fsm_pkg::ST_COLD_ACT || card_state == rcr_fsm_pkg::ST_HOT_ACT), "active raised outside an active role")
	`RCR_ASSERT(a_rtc_in_hot_act, (result_valid && rtc_sync_request) |-> (card_state == rcr_fsm_pkg::ST_HOT_ACT && state_ticks == rcr_fsm_pkg::SETTLE_TICKS), "rtc sync request outside settled hot active")
	`RCR_ASSERT_ALWAYS(a_reset_empties_result, !arst_n |=> !result_valid, "result valid right after reset")

endmodule

// File: dv/tb_redundant_card_role_fsm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redundant_card_role_fsm_top
// self-checking bench for the redundant card role controller
// ----------------------------------------------------------------------------
// Drives ticks, twin reports and fail/offline commands through the item
// channel and compares each result transaction field by field with a
// role-state predictor kept in the bench. Covers the cold/hot active and
// standby walk, the rtc sync request, cross-sync loss and recovery, random
// traffic under three idling profiles, a long output hold-off, and the
// fail/offline roles last since they never return.
// ----------------------------------------------------------------------------
module tb_redundant_card_role_fsm_top;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		rcr_fsm_pkg::role_t  card_state;
		logic                state_changed;
		logic                tick_status;
		rcr_fsm_pkg::event_t active_event;
		rcr_fsm_pkg::event_t standby_event;
		rcr_fsm_pkg::event_t xsync_event;
		logic                rtc_sync_request;
		rcr_fsm_pkg::role_t  twin_state;
		logic [14:0]         twin_freshness;
		logic [31:0]         state_ticks;
	} card_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	rcr_fsm_pkg::func_t   func = rcr_fsm_pkg::FN_TICK;
	rcr_fsm_pkg::hw_role_t fpga_active = rcr_fsm_pkg::HW_STANDBY;
	logic                 is_warm = 1'b0;
	logic                 xsync_ok = 1'b1;
	rcr_fsm_pkg::role_t   twin_code = rcr_fsm_pkg::ST_WARMUP;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [2:0]           card_state;
	logic                 state_changed;
	logic                 tick_status;
	logic [1:0]           active_event;
	logic [1:0]           standby_event;
	logic [1:0]           xsync_event;
	logic                 rtc_sync_request;
	logic [2:0]           twin_state;
	logic [14:0]          twin_freshness;
	logic [31:0]          state_ticks;

	// predictor state
	rcr_fsm_pkg::role_t  pr_role = rcr_fsm_pkg::ST_WARMUP;
	logic [31:0]         pr_ticks = '0;
	rcr_fsm_pkg::role_t  pr_twin = rcr_fsm_pkg::ST_WARMUP;
	logic [14:0]         pr_age = rcr_fsm_pkg::AGE_REWIND;
	logic                pr_sync = 1'b1;
	rcr_fsm_pkg::event_t act_ev;
	rcr_fsm_pkg::event_t stby_ev;
	rcr_fsm_pkg::event_t xsync_ev;

	card_result_t pending_card_results[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	rcr_fsm_pkg::hw_role_t cur_hw = rcr_fsm_pkg::HW_STANDBY;

	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int rtc_requests = 0;
	int xsync_losses = 0;
	int input_stall_cycles = 0;

	redundant_card_role_fsm_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.fpga_active(fpga_active),
		.is_warm(is_warm),
		.xsync_ok(xsync_ok),
		.twin_code(twin_code),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.card_state(card_state),
		.state_changed(state_changed),
		.tick_status(tick_status),
		.active_event(active_event),
		.standby_event(standby_event),
		.xsync_event(xsync_event),
		.rtc_sync_request(rtc_sync_request),
		.twin_state(twin_state),
		.twin_freshness(twin_freshness),
		.state_ticks(state_ticks)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// role move with its raise/clear events; returns 1 on a real change
	function automatic logic move_to(rcr_fsm_pkg::role_t nxt);
		rcr_fsm_pkg::role_t prev;
		prev = pr_role;
		if (prev == nxt)
			return 1'b0;
		if (prev == rcr_fsm_pkg::ST_COLD_ACT && nxt != rcr_fsm_pkg::ST_HOT_ACT)
			act_ev = rcr_fsm_pkg::EV_CLEAR;
		if (prev == rcr_fsm_pkg::ST_HOT_ACT && nxt != rcr_fsm_pkg::ST_COLD_ACT)
			act_ev = rcr_fsm_pkg::EV_CLEAR;
		if (prev == rcr_fsm_pkg::ST_COLD_STBY && nxt != rcr_fsm_pkg::ST_HOT_STBY)
			stby_ev = rcr_fsm_pkg::EV_CLEAR;
		if (prev == rcr_fsm_pkg::ST_HOT_STBY) begin
			if (nxt != rcr_fsm_pkg::ST_COLD_STBY) stby_ev = rcr_fsm_pkg::EV_CLEAR;
			if (!pr_sync) begin
				pr_sync = 1'b1;
				xsync_ev = rcr_fsm_pkg::EV_CLEAR;
			end
		end
		pr_role = nxt;
		if (nxt == rcr_fsm_pkg::ST_COLD_ACT && prev != rcr_fsm_pkg::ST_HOT_ACT)
			act_ev = rcr_fsm_pkg::EV_RAISE;
		if (nxt == rcr_fsm_pkg::ST_HOT_ACT && prev != rcr_fsm_pkg::ST_COLD_ACT)
			act_ev = rcr_fsm_pkg::EV_RAISE;
		if (nxt == rcr_fsm_pkg::ST_COLD_STBY && prev != rcr_fsm_pkg::ST_HOT_STBY)
			stby_ev = rcr_fsm_pkg::EV_RAISE;
		if (nxt == rcr_fsm_pkg::ST_HOT_STBY && prev != rcr_fsm_pkg::ST_COLD_STBY)
			stby_ev = rcr_fsm_pkg::EV_RAISE;
		pr_ticks = '0;
		// an active twin cannot coexist with this card going active
		if ((nxt == rcr_fsm_pkg::ST_COLD_ACT || nxt == rcr_fsm_pkg::ST_HOT_ACT) &&
			(pr_twin == rcr_fsm_pkg::ST_COLD_ACT || pr_twin == rcr_fsm_pkg::ST_HOT_ACT))
			pr_twin = rcr_fsm_pkg::ST_UNKNOWN;
		return 1'b1;
	endfunction

	function automatic card_result_t predict_card_result(rcr_fsm_pkg::func_t fn,
			rcr_fsm_pkg::hw_role_t act, logic warm, logic xs, rcr_fsm_pkg::role_t code);
		card_result_t r;
		logic chg;
		logic rtc;
		logic tstat;
		chg = 1'b0;
		rtc = 1'b0;
		tstat = 1'b0;
		act_ev = rcr_fsm_pkg::EV_NONE;
		stby_ev = rcr_fsm_pkg::EV_NONE;
		xsync_ev = rcr_fsm_pkg::EV_NONE;
		case (fn)
			rcr_fsm_pkg::FN_TICK: begin
				pr_age = pr_age + 15'd1;
				if (pr_age >= rcr_fsm_pkg::AGE_LIMIT)
					pr_age = rcr_fsm_pkg::AGE_REWIND;
				if (pr_ticks != '1)
					pr_ticks = pr_ticks + 32'd1;
				case (pr_role)
					rcr_fsm_pkg::ST_WARMUP: begin
						if (act == rcr_fsm_pkg::HW_ACTIVE)
							chg = move_to(rcr_fsm_pkg::ST_COLD_ACT);
						else if (act == rcr_fsm_pkg::HW_STANDBY)
							chg = move_to(rcr_fsm_pkg::ST_COLD_STBY);
					end
					rcr_fsm_pkg::ST_COLD_ACT, rcr_fsm_pkg::ST_COLD_STBY: begin
						if (warm && act == rcr_fsm_pkg::HW_ACTIVE)
							chg = move_to(rcr_fsm_pkg::ST_HOT_ACT);
						else if (warm && act == rcr_fsm_pkg::HW_STANDBY)
							chg = move_to(rcr_fsm_pkg::ST_HOT_STBY);
						else if (pr_role == rcr_fsm_pkg::ST_COLD_ACT &&
							act == rcr_fsm_pkg::HW_STANDBY)
							chg = move_to(rcr_fsm_pkg::ST_COLD_STBY);
						else if (pr_role == rcr_fsm_pkg::ST_COLD_STBY &&
							act == rcr_fsm_pkg::HW_ACTIVE)
							chg = move_to(rcr_fsm_pkg::ST_COLD_ACT);
					end
					rcr_fsm_pkg::ST_HOT_ACT: begin
						if (act == rcr_fsm_pkg::HW_ACTIVE) begin
							if (pr_ticks == rcr_fsm_pkg::SETTLE_TICKS) rtc = 1'b1;
						end else if (act == rcr_fsm_pkg::HW_STANDBY) begin
							chg = move_to(rcr_fsm_pkg::ST_HOT_STBY);
						end
					end
					rcr_fsm_pkg::ST_HOT_STBY: begin
						if (act == rcr_fsm_pkg::HW_ACTIVE) begin
							chg = move_to(rcr_fsm_pkg::ST_HOT_ACT);
						end else if (pr_ticks > rcr_fsm_pkg::SETTLE_TICKS) begin
							if (pr_sync && !xs) begin
								pr_sync = 1'b0;
								xsync_ev = rcr_fsm_pkg::EV_RAISE;
							end else if (!pr_sync && xs) begin
								pr_sync = 1'b1;
								xsync_ev = rcr_fsm_pkg::EV_CLEAR;
							end
						end
					end
					default: ;
				endcase
				tstat = chg || pr_role == rcr_fsm_pkg::ST_FAIL ||
					pr_role == rcr_fsm_pkg::ST_OFFLINE;
			end
			rcr_fsm_pkg::FN_TWIN: begin
				if (pr_twin != code) begin
					pr_twin = code;
					pr_ticks = '0;
				end
				pr_age = '0;
			end
			rcr_fsm_pkg::FN_FAIL: chg = move_to(rcr_fsm_pkg::ST_FAIL);
			default: chg = move_to(rcr_fsm_pkg::ST_OFFLINE);
		endcase
		r.card_state = pr_role;
		r.state_changed = chg;
		r.tick_status = tstat;
		r.active_event = act_ev;
		r.standby_event = stby_ev;
		r.xsync_event = xsync_ev;
		r.rtc_sync_request = rtc;
		r.twin_state = pr_twin;
		r.twin_freshness = pr_age;
		r.state_ticks = pr_ticks;
		return r;
	endfunction

	function automatic string fmt_result(card_result_t r);
		return $sformatf({"role=%0d chg=%0d tst=%0d act=%0d stby=%0d xs=%0d rtc=%0d",
			" twin=%0d fresh=%0d ticks=%0d"},
			r.card_state, r.state_changed, r.tick_status, r.active_event, r.standby_event,
			r.xsync_event, r.rtc_sync_request, r.twin_state, r.twin_freshness, r.state_ticks);
	endfunction

	// one transaction on the item channel; returns at the accepting edge
	task automatic send_item(rcr_fsm_pkg::func_t fn, rcr_fsm_pkg::hw_role_t act, logic warm,
			logic xs, rcr_fsm_pkg::role_t code);
		card_result_t exp_r;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		func <= fn;
		fpga_active <= act;
		is_warm <= warm;
		xsync_ok <= xs;
		twin_code <= code;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		exp_r = predict_card_result(fn, act, warm, xs, code);
		pending_card_results.push_back(exp_r);
		items_sent++;
		if (exp_r.rtc_sync_request) rtc_requests++;
		if (exp_r.xsync_event == rcr_fsm_pkg::EV_RAISE) xsync_losses++;
	endtask

	task automatic tick(rcr_fsm_pkg::hw_role_t act, logic warm, logic xs);
		send_item(rcr_fsm_pkg::FN_TICK, act, warm, xs, rcr_fsm_pkg::role_t'($urandom_range(7)));
	endtask

	task automatic twin_report(rcr_fsm_pkg::role_t code);
		send_item(rcr_fsm_pkg::FN_TWIN, rcr_fsm_pkg::hw_role_t'($urandom_range(3)),
			1'($urandom_range(1)), 1'($urandom_range(1)), code);
	endtask

	task automatic send_command(rcr_fsm_pkg::func_t fn);
		send_item(fn, rcr_fsm_pkg::hw_role_t'($urandom_range(3)), 1'($urandom_range(1)),
			1'($urandom_range(1)), rcr_fsm_pkg::role_t'($urandom_range(7)));
	endtask

	// hardware role is sticky so hot states last long enough to settle
	task automatic send_random_item(bit any_func);
		rcr_fsm_pkg::func_t fn;
		int r;
		rcr_fsm_pkg::role_t code;
		if ($urandom_range(99) < 30) begin
			r = $urandom_range(99);
			if (r < 40) cur_hw = rcr_fsm_pkg::HW_STANDBY;
			else if (r < 75) cur_hw = rcr_fsm_pkg::HW_ACTIVE;
			else cur_hw = rcr_fsm_pkg::hw_role_t'($urandom_range(3, 2));
		end
		if (any_func) fn = rcr_fsm_pkg::func_t'($urandom_range(3));
		else fn = ($urandom_range(99) < 80) ? rcr_fsm_pkg::FN_TICK : rcr_fsm_pkg::FN_TWIN;
		code = ($urandom_range(1) == 0) ? pr_twin : rcr_fsm_pkg::role_t'($urandom_range(7));
		send_item(fn, cur_hw, 1'($urandom_range(1)), 1'($urandom_range(1)), code);
	endtask

	task automatic test_role_walk();
		int k;
		twin_report(rcr_fsm_pkg::ST_WARMUP);
		twin_report(rcr_fsm_pkg::ST_COLD_STBY);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b0, 1'b1);
		tick(rcr_fsm_pkg::HW_ACTIVE, 1'b0, 1'b1);
		twin_report(rcr_fsm_pkg::ST_HOT_ACT);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b0, 1'b1);
		tick(rcr_fsm_pkg::HW_ACTIVE, 1'b0, 1'b1);
		twin_report(rcr_fsm_pkg::ST_HOT_ACT);
		// either straight to hot active or through hot standby
		if ($urandom_range(1) == 0) begin
			tick(rcr_fsm_pkg::HW_ACTIVE, 1'b1, 1'b1);
		end else begin
			tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b1);
			tick(rcr_fsm_pkg::HW_ACTIVE, 1'b1, 1'b1);
		end
		for (k = 0; k < 3; k++)
			tick(rcr_fsm_pkg::HW_ACTIVE, 1'b1, 1'b1);
		tick(rcr_fsm_pkg::hw_role_t'(2'd2), 1'b1, 1'b1);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b1);
		for (k = 0; k < 3; k++)
			tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b1);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b0);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b1);
		tick(rcr_fsm_pkg::hw_role_t'(2'd3), 1'b1, 1'b0);
		// leave hot standby with sync lost
		tick(rcr_fsm_pkg::HW_ACTIVE, 1'b1, 1'b1);
	endtask

	task automatic test_random_traffic(int count);
		repeat (count)
			send_random_item(1'b0);
	endtask

	task automatic test_backpressure();
		hold_request = 1;
		repeat (30)
			send_random_item(1'b0);
	endtask

	task automatic test_fail_offline();
		int k;
		// steer into hot standby with cross sync lost first
		for (k = 0; k < 20 && !(pr_role == rcr_fsm_pkg::ST_HOT_STBY && !pr_sync); k++)
			tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b0);
		send_command(rcr_fsm_pkg::FN_FAIL);
		send_command(rcr_fsm_pkg::FN_FAIL);
		tick(rcr_fsm_pkg::HW_ACTIVE, 1'b1, 1'b1);
		twin_report(rcr_fsm_pkg::ST_UNKNOWN);
		send_command(rcr_fsm_pkg::FN_OFFLINE);
		send_command(rcr_fsm_pkg::FN_OFFLINE);
		tick(rcr_fsm_pkg::HW_STANDBY, 1'b1, 1'b0);
		send_command(rcr_fsm_pkg::FN_FAIL);
		repeat (150)
			send_random_item(1'b1);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (hold_request != 0) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		card_result_t got;
		card_result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			got = {card_state, state_changed, tick_status, active_event, standby_event,
				xsync_event, rtc_sync_request, twin_state, twin_freshness, state_ticks};
			if (pending_card_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %s", fmt_result(got));
			end else begin
				exp_r = pending_card_results.pop_front();
				results_checked++;
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d", results_checked);
						$display("  expected %s", fmt_result(exp_r));
						$display("  actual   %s", fmt_result(got));
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_stall)
				input_stall_cycles++;
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		send_idle_pct = 25;
		stall_pct = 67;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_role_walk();
		test_random_traffic(550);
		send_idle_pct = 67;
		stall_pct = 25;
		test_random_traffic(550);
		send_idle_pct = 0;
		stall_pct = 0;
		test_backpressure();
		test_random_traffic(500);
		test_fail_offline();

		item_valid <= 1'b0;
		while (pending_card_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d transactions sent, %0d results checked, %0d input stall cycles",
			items_sent, results_checked, input_stall_cycles);
		$display("%0d rtc sync requests, %0d xsync losses, role walk and fail/offline roles",
			rtc_requests, xsync_losses);
		if (mismatches == 0 && pending_card_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/rcr_fsm_pkg.sv
sv/redundant_card_role_fsm_top.sv
dv/tb_redundant_card_role_fsm_top.sv
